FILE: design/fbs_pkg.sv
// Package: constants, codes and stage types for the FEC batch sizing block.
package fbs_pkg;

  localparam int Q_BITS = 16;
  localparam int Q_W    = Q_BITS + 1;

  localparam logic [Q_W-1:0] Q_ONE         = Q_W'(1 << Q_BITS);
  localparam logic [Q_W-1:0] Q_EXTRA       = Q_W'((5 * (1 << Q_BITS) + 50) / 100);
  localparam logic [Q_W-1:0] Q_START_DATA  = Q_W'((13 * (1 << Q_BITS) + 10) / 20);
  localparam logic [Q_W-1:0] Q_START_OTHER = Q_W'((17 * (1 << Q_BITS) + 10) / 20);
  localparam logic [Q_W-1:0] Q_MAXLOSS     = Q_W'((9 * (1 << Q_BITS) + 5) / 10);

  localparam logic [1:0] CMD_DATA    = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_RETX    = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_BADK = 2'd2;

  localparam logic [1:0] CFG_FEC  = 2'd0;
  localparam logic [1:0] CFG_MAXK = 2'd1;
  localparam logic [1:0] CFG_GF   = 2'd2;

  // small dividers: 8-bit count over a Q fraction; fit divider: 32 over 33
  localparam int DIV_NW = 8 + Q_BITS;
  localparam int DIV_DW = Q_W;
  localparam int FIT_NW = 32;
  localparam int FIT_DW = 33;
  localparam int CEIL_W = DIV_NW + 1;

  typedef struct packed {
    logic [1:0]     cmd;
    logic [31:0]    coh;
    logic [31:0]    extra;
    logic           rate_zero;
    logic [7:0]     gk;
    logic [Q_W-1:0] loss;
    logic           spare_ok;
    logic           r_lt_one;
    logic [Q_W-1:0] den_a;
  } fbs_a_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        gk;
    logic [Q_W-1:0]    loss;
    logic              spare_ok;
    logic              r_lt_one;
    logic [Q_W-1:0]    den_a;
    logic              zero;
    logic [CEIL_W-1:0] ceil_a;
    logic [CEIL_W-1:0] ceil_b;
  } fbs_b_t;

  typedef struct packed {
    fbs_b_t             b;
    logic [31:0]        fit;
    logic [32+Q_W-1:0]  prod;
    logic               cmp1;
    logic [7:0]         fitc;
  } fbs_p1_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        gk;
    logic [Q_W-1:0]    loss;
    logic              spare_ok;
    logic              zero;
    logic [7:0]        fitc;
    logic [7:0]        k8;
    logic [7:0]        n8;
    logic [7:0]        nfo;
    logic [CEIL_W-1:0] n_mid;
    logic [CEIL_W-1:0] ceil_b;
  } fbs_p2_t;

endpackage

FILE: design/fec_block_sizing.sv
// Top level: pipelined erasure-code batch sizing (k source, n coded packets).
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------
//  in      | in_cmd .. in_loss_known        | in_valid / in_stall
//  out     | out_k_out, out_n_out, out_status | out_valid / out_stall
//  cfg     | cfg_we, cfg_index, cfg_data    | write on cfg_we, no wait
//
// One request enters per cycle while the output is not stalled; each result passes one input
// stage, 24 stages of the packet-time and ceil dividers, one duration stage,
// 32 stages of the coherence-time divider, two sizing stages and the output
// register. The dividers make up most of that depth.
// Reset clears all valid bits and loads fec_enable 1, max k 32, field limit 250.
// A stalled result stalls the whole pipeline in place; nothing is lost.
module fec_block_sizing
  import fbs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_cmd,
  input  logic [31:0]    in_coherence_us,
  input  logic [15:0]    in_packet_bytes,
  input  logic [31:0]    in_overhead_us,
  input  logic [15:0]    in_link_rate,
  input  logic [7:0]     in_given_k,
  input  logic [Q_W-1:0] in_loss_fraction,
  input  logic           in_loss_known,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_k_out,
  output logic [7:0]     out_n_out,
  output logic [1:0]     out_status,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  // configuration registers
  logic       fec_en_r;
  logic [7:0] maxk_r;
  logic [7:0] gf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fec_en_r <= 1'b1;
      maxk_r   <= 8'd32;
      gf_r     <= 8'd250;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEC:  fec_en_r <= cfg_data[0];
        CFG_MAXK: maxk_r   <= cfg_data;
        CFG_GF:   gf_r     <= cfg_data;
        default:  ;
      endcase
    end
  end

  // advance the whole pipeline unless a finished result is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage A: register the request, derive redundancy
  logic [Q_W:0]   r_w;
  logic           r_lt_one_w;
  logic [Q_W-1:0] den_a_w;
  logic           spare_ok_w;

  always_comb begin
    if (in_loss_known) begin
      r_w = {1'b0, in_loss_fraction} + {1'b0, Q_EXTRA};
    end else if (in_cmd == CMD_DATA) begin
      r_w = {1'b0, Q_START_DATA};
    end else begin
      r_w = {1'b0, Q_START_OTHER};
    end
    r_lt_one_w = r_w < {1'b0, Q_ONE};
    den_a_w    = r_lt_one_w ? Q_ONE - r_w[Q_W-1:0] : '0;
    spare_ok_w = in_loss_known && (in_loss_fraction <= Q_MAXLOSS);
  end

  logic                a_v_r;
  fbs_a_t              a_r;
  logic [DIV_NW-1:0]   d1_num_r, da_num_r, db_num_r;
  logic [DIV_DW-1:0]   d1_den_r, da_den_r, db_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.cmd       <= in_cmd;
      a_r.coh       <= in_coherence_us;
      a_r.extra     <= in_overhead_us;
      a_r.rate_zero <= (in_link_rate == '0);
      a_r.gk        <= in_given_k;
      a_r.loss      <= in_loss_fraction;
      a_r.spare_ok  <= spare_ok_w;
      a_r.r_lt_one  <= r_lt_one_w;
      a_r.den_a     <= den_a_w;
      // bytes * 80 as two shifts
      d1_num_r <= DIV_NW'({in_packet_bytes, 6'b0}) + DIV_NW'({in_packet_bytes, 4'b0});
      d1_den_r <= (in_link_rate == '0) ? DIV_DW'(1) : DIV_DW'(in_link_rate);
      da_num_r <= {((in_cmd == CMD_DATA) ? maxk_r : in_given_k), {Q_BITS{1'b0}}};
      da_den_r <= r_lt_one_w ? den_a_w : DIV_DW'(1);
      db_num_r <= {in_given_k, {Q_BITS{1'b0}}};
      db_den_r <= spare_ok_w ? Q_ONE - in_loss_fraction : DIV_DW'(1);
    end
  end

  // ---------------- packet time and ceil dividers, side data alongside
  logic [DIV_NW-1:0] d1_quo, da_quo, db_quo;
  logic [DIV_DW-1:0] da_rem, db_rem;

  fbs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_time (
    .clk(clk), .en(en), .num(d1_num_r), .den(d1_den_r), .quo(d1_quo), .rem()
  );
  fbs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_red (
    .clk(clk), .en(en), .num(da_num_r), .den(da_den_r), .quo(da_quo), .rem(da_rem)
  );
  fbs_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_loss (
    .clk(clk), .en(en), .num(db_num_r), .den(db_den_r), .quo(db_quo), .rem(db_rem)
  );

  fbs_a_t            s1_r [DIV_NW];
  logic [DIV_NW-1:0] v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r[0] <= a_r;
      for (int i = 1; i < DIV_NW; i++) begin
        s1_r[i] <= s1_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
    end else if (en) begin
      v1_r <= {v1_r[DIV_NW-2:0], a_v_r};
    end
  end

  // ---------------- stage B: packet duration and ceilings
  fbs_a_t      s1_last;
  logic [32:0] dur_w;
  logic        zero_w;

  assign s1_last = s1_r[DIV_NW-1];
  assign dur_w   = {1'b0, s1_last.extra} + 33'(d1_quo);
  assign zero_w  = s1_last.rate_zero || (dur_w == '0);

  logic              b_v_r;
  fbs_b_t            b_r;
  logic [31:0]       b_coh_r;
  logic [FIT_DW-1:0] b_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= v1_r[DIV_NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r.cmd      <= s1_last.cmd;
      b_r.gk       <= s1_last.gk;
      b_r.loss     <= s1_last.loss;
      b_r.spare_ok <= s1_last.spare_ok;
      b_r.r_lt_one <= s1_last.r_lt_one;
      b_r.den_a    <= s1_last.den_a;
      b_r.zero     <= zero_w;
      b_r.ceil_a   <= CEIL_W'(da_quo) + CEIL_W'(da_rem != '0);
      b_r.ceil_b   <= CEIL_W'(db_quo) + CEIL_W'(db_rem != '0);
      b_coh_r      <= s1_last.coh;
      b_den_r      <= zero_w ? FIT_DW'(1) : dur_w;
    end
  end

  // ---------------- packets that fit in the coherence time
  logic [FIT_NW-1:0] fit_quo;

  fbs_div #(.NW(FIT_NW), .DW(FIT_DW)) u_div_fit (
    .clk(clk), .en(en), .num(b_coh_r), .den(b_den_r), .quo(fit_quo), .rem()
  );

  fbs_b_t            s2_r [FIT_NW];
  logic [FIT_NW-1:0] v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r[0] <= b_r;
      for (int i = 1; i < FIT_NW; i++) begin
        s2_r[i] <= s2_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= '0;
    end else if (en) begin
      v2_r <= {v2_r[FIT_NW-2:0], b_v_r};
    end
  end

  // ---------------- stage P1: products and limits
  fbs_b_t      s2_last;
  logic [7:0]  gf_m1;
  logic [24:0] cap_prod;

  assign s2_last  = s2_r[FIT_NW-1];
  assign gf_m1    = gf_r - 8'd1;
  assign cap_prod = 25'(s2_last.den_a) * 25'(gf_m1);

  logic    p1_v_r;
  fbs_p1_t p1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= v2_r[FIT_NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r.b    <= s2_last;
      p1_r.fit  <= fit_quo;
      p1_r.prod <= fit_quo * s2_last.den_a;
      // redundancy cap: den*(gf-1) below k*ONE, always when r reaches one
      p1_r.cmp1 <= !s2_last.r_lt_one || (cap_prod < 25'({s2_last.gk, {Q_BITS{1'b0}}}));
      p1_r.fitc <= (fit_quo > 32'(gf_r)) ? gf_r : fit_quo[7:0];
    end
  end

  // ---------------- stage P2: k and n before the spare packet
  logic [31:0] k32_w;
  logic        kbig_w;
  logic [31:0] npre_w;
  logic [CEIL_W-1:0] nmid_w;

  assign k32_w  = p1_r.prod[Q_BITS+31:Q_BITS];
  assign kbig_w = k32_w > 32'(maxk_r);
  assign npre_w = kbig_w ? 32'(p1_r.b.ceil_a) : p1_r.fit;

  always_comb begin
    if (p1_r.b.cmd == CMD_TIMEOUT) begin
      if (gf_r < 8'd2) begin
        nmid_w = '0;
      end else if (p1_r.cmp1) begin
        nmid_w = CEIL_W'(gf_m1);
      end else begin
        nmid_w = p1_r.b.ceil_a;
      end
    end else begin
      nmid_w = p1_r.b.r_lt_one ? p1_r.b.ceil_a : CEIL_W'(p1_r.fitc);
    end
  end

  logic    p2_v_r;
  fbs_p2_t p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r.cmd      <= p1_r.b.cmd;
      p2_r.gk       <= p1_r.b.gk;
      p2_r.loss     <= p1_r.b.loss;
      p2_r.spare_ok <= p1_r.b.spare_ok;
      p2_r.zero     <= p1_r.b.zero;
      p2_r.fitc     <= p1_r.fitc;
      p2_r.k8       <= kbig_w ? maxk_r : k32_w[7:0];
      p2_r.n8       <= (npre_w > 32'(gf_r)) ? gf_r : npre_w[7:0];
      p2_r.nfo      <= (p1_r.fit > 32'(maxk_r)) ? maxk_r : p1_r.fit[7:0];
      p2_r.n_mid    <= nmid_w;
      p2_r.ceil_b   <= p1_r.b.ceil_b;
    end
  end

  // ---------------- output stage: spare packet, status, final select
  logic [Q_W-1:0]    keep_w;
  logic [Q_W+7:0]    kne_prod;
  logic [7:0]        kne_w;
  logic [7:0]        k0_w;
  logic [CEIL_W:0]   ne_w;
  logic [7:0]        lim_w;
  logic [CEIL_W:0]   nsel_w;
  logic [7:0]        nfin_w;
  logic [7:0]        k_w;
  logic [7:0]        n_w;
  logic [1:0]        st_w;

  assign keep_w   = Q_ONE - p2_r.loss;
  assign kne_prod = (Q_W+8)'(p2_r.n8) * (Q_W+8)'(keep_w);
  assign kne_w    = kne_prod[Q_BITS+7:Q_BITS];
  assign ne_w     = (CEIL_W+1)'(p2_r.ceil_b) + (CEIL_W+1)'(1);
  assign lim_w    = (p2_r.cmd == CMD_TIMEOUT) ? gf_r : p2_r.fitc;

  always_comb begin
    // new data: keep one spare packet, never less than one source packet
    k0_w = p2_r.k8;
    if (p2_r.spare_ok) begin
      if (kne_w == '0) begin
        k0_w = 8'd1;
      end else if (kne_w - 8'd1 < p2_r.k8) begin
        k0_w = kne_w - 8'd1;
      end
    end
    if (k0_w == '0) begin
      k0_w = 8'd1;
    end

    // timeout and retransmission: raise n to the spare count when allowed
    nsel_w = (CEIL_W+1)'(p2_r.n_mid);
    if (p2_r.spare_ok && (nsel_w < ne_w) && (ne_w <= (CEIL_W+1)'(lim_w))) begin
      nsel_w = ne_w;
    end
    nfin_w = (nsel_w > (CEIL_W+1)'(lim_w)) ? lim_w : nsel_w[7:0];

    case (p2_r.cmd)
      CMD_DATA: begin
        if (p2_r.zero) begin
          k_w = '0; n_w = '0; st_w = ST_ZERO;
        end else if (!fec_en_r) begin
          k_w = p2_r.nfo; n_w = p2_r.nfo; st_w = ST_OK;
        end else begin
          k_w = k0_w; n_w = p2_r.n8; st_w = ST_OK;
        end
      end
      CMD_TIMEOUT: begin
        k_w = p2_r.gk;
        if (p2_r.gk == '0 || p2_r.gk >= maxk_r) begin
          n_w = '0; st_w = ST_BADK;
        end else if (!fec_en_r) begin
          n_w = p2_r.gk; st_w = ST_OK;
        end else begin
          n_w = nfin_w; st_w = ST_OK;
        end
      end
      default: begin
        // retransmission; the unused selector takes the same path
        k_w = p2_r.gk;
        if (p2_r.zero) begin
          n_w = '0; st_w = ST_ZERO;
        end else if (p2_r.gk == '0 || p2_r.gk > p2_r.fitc || p2_r.gk > maxk_r) begin
          n_w = '0; st_w = ST_BADK;
        end else if (!fec_en_r) begin
          n_w = p2_r.gk; st_w = ST_OK;
        end else begin
          n_w = nfin_w; st_w = ST_OK;
        end
      end
    endcase
  end

  logic       out_valid_r;
  logic [7:0] out_k_r;
  logic [7:0] out_n_r;
  logic [1:0] out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p2_v_r) begin
      out_k_r  <= k_w;
      out_n_r  <= n_w;
      out_st_r <= st_w;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_k_out  = out_k_r;
  assign out_n_out  = out_n_r;
  assign out_status = out_st_r;

  // ---------------- checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled while output is free");

  a_error_has_no_n: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |-> (out_n_r == '0))
    else $error("error status with nonzero n");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_st_r == ST_OK || out_st_r == ST_ZERO || out_st_r == ST_BADK))
    else $error("undefined status code");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

FILE: design/fbs_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module fbs_div #(
  parameter int NW = 24,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [NW-1:0] nq_r [NW];
  logic [DW-1:0] rm_r [NW];
  logic [DW-1:0] dv_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rm_in;
    logic [DW-1:0] dv_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign nq_in = num;
      assign rm_in = '0;
      assign dv_in = den;
    end else begin : g_next
      assign nq_in = nq_r[i-1];
      assign rm_in = rm_r[i-1];
      assign dv_in = dv_r[i-1];
    end

    assign trial = {rm_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        nq_r[i] <= {nq_in[NW-2:0], ~diff[DW]};
        rm_r[i] <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        dv_r[i] <= dv_in;
      end
    end
  end

  assign quo = nq_r[NW-1];
  assign rem = rm_r[NW-1];

endmodule

FILE: verif/fec_block_sizing_check.sv
// Checker for the FEC batch sizing block: predicts each batch decision and compares results.
module fec_block_sizing_check
  import fbs_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic [1:0]     in_cmd,
  input  logic [31:0]    in_coherence_us,
  input  logic [15:0]    in_packet_bytes,
  input  logic [31:0]    in_overhead_us,
  input  logic [15:0]    in_link_rate,
  input  logic [7:0]     in_given_k,
  input  logic [Q_W-1:0] in_loss_fraction,
  input  logic           in_loss_known,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic [7:0]     out_k_out,
  input  logic [7:0]     out_n_out,
  input  logic [1:0]     out_status,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  output int             errors,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] k;
    logic [7:0] n;
    logic [1:0] st;
  } batch_t;

  logic       fec_on;
  logic [7:0] max_k;
  logic [7:0] gf_lim;
  batch_t     batch_q[$];

  function automatic longint ceil_div(longint a, longint b);
    return (b != 0) ? (a + b - 1) / b : 0;
  endfunction

  function automatic batch_t size_batch(logic [1:0] cmd, longint coh, longint bytes,
                                        longint extra, longint rate, longint gk,
                                        longint loss, logic known);
    longint maxk, gf, dur, n, fit, r, k, kne, den, ne;
    logic spare;
    batch_t b;
    maxk  = max_k;
    gf    = gf_lim;
    spare = known && (loss <= Q_MAXLOSS);
    dur   = (rate == 0) ? 0 : (bytes * 80) / rate + extra;
    if (cmd == CMD_DATA) begin
      if (dur == 0) return '{8'd0, 8'd0, ST_ZERO};
      n = coh / dur;
      if (!fec_on) begin
        if (n > maxk) n = maxk;
        return '{n[7:0], n[7:0], ST_OK};
      end
      r = known ? loss + Q_EXTRA : Q_START_DATA;
      k = (r >= Q_ONE) ? 0 : (n * (Q_ONE - r)) >>> Q_BITS;
      if (k > maxk) begin
        k = maxk;
        n = ceil_div(maxk * Q_ONE, Q_ONE - r);
      end
      if (n > gf) n = gf;
      if (spare) begin
        kne = (n * (Q_ONE - loss)) >>> Q_BITS;
        if (kne - 1 < k) k = kne - 1;
      end
      if (k <= 0) k = 1;
      return '{k[7:0], n[7:0], ST_OK};
    end
    if (cmd == CMD_TIMEOUT) begin
      if (gk == 0 || gk >= maxk) return '{gk[7:0], 8'd0, ST_BADK};
      if (!fec_on) return '{gk[7:0], gk[7:0], ST_OK};
      r = known ? loss + Q_EXTRA : Q_START_OTHER;
      if (gf < 2) n = 0;
      else begin
        // signed compare: den goes negative when the redundancy passes one
        den = Q_ONE - r;
        if (den * (gf - 1) < gk * longint'(Q_ONE)) n = gf - 1;
        else n = ceil_div(gk * Q_ONE, den);
      end
      if (spare) begin
        ne = ceil_div(gk * Q_ONE, Q_ONE - loss) + 1;
        if (n < ne && ne <= gf) n = ne;
      end
      if (n > gf) n = gf;
      return '{gk[7:0], n[7:0], ST_OK};
    end
    // retransmission, also for the unused fourth selector
    if (dur == 0) return '{gk[7:0], 8'd0, ST_ZERO};
    fit = coh / dur;
    if (fit > gf) fit = gf;
    if (gk == 0 || gk > fit || gk > maxk) return '{gk[7:0], 8'd0, ST_BADK};
    if (!fec_on) return '{gk[7:0], gk[7:0], ST_OK};
    r = known ? loss + Q_EXTRA : Q_START_OTHER;
    n = (r < Q_ONE) ? ceil_div(gk * Q_ONE, Q_ONE - r) : fit;
    if (spare) begin
      ne = ceil_div(gk * Q_ONE, Q_ONE - loss) + 1;
      if (n < ne && ne <= fit) n = ne;
    end
    if (n > fit) n = fit;
    b = '{gk[7:0], n[7:0], ST_OK};
    return b;
  endfunction

  assign pending = batch_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    batch_t exp_b;
    if (!rst_n) begin
      fec_on <= 1'b1;
      max_k  <= 8'd32;
      gf_lim <= 8'd250;
      batch_q.delete();
    end else begin
      if (in_valid && !in_stall)
        batch_q.insert(batch_q.size(),
                       size_batch(in_cmd, in_coherence_us, in_packet_bytes,
                                  in_overhead_us, in_link_rate, in_given_k,
                                  in_loss_fraction, in_loss_known));
      if (out_valid && !out_stall) begin
        if (batch_q.size() == 0) begin
          errors <= errors + 1;
          $display("%0t: unexpected result k=%0d n=%0d st=%0d", $time,
                   out_k_out, out_n_out, out_status);
        end else begin
          exp_b = batch_q.pop_front();
          if (exp_b !== {out_k_out, out_n_out, out_status}) begin
            errors <= errors + 1;
            $display("%0t: expected k=%0d n=%0d st=%0d, actual k=%0d n=%0d st=%0d",
                     $time, exp_b.k, exp_b.n, exp_b.st, out_k_out, out_n_out,
                     out_status);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_FEC:  fec_on <= cfg_data[0];
          CFG_MAXK: max_k  <= cfg_data;
          CFG_GF:   gf_lim <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: verif/fec_block_sizing_test.sv
// Testbench top: drives batch requests and settings into the sizing block, reports the verdict.
module fec_block_sizing_test;
  import fbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_SPARE_SEL = 2'd3;  // unused selector, behaves as retransmission
  localparam int         DRAIN_CYCLES  = 80;    // pipeline is 61 deep

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [1:0]     in_cmd = '0;
  logic [31:0]    in_coherence_us = '0;
  logic [15:0]    in_packet_bytes = '0;
  logic [31:0]    in_overhead_us = '0;
  logic [15:0]    in_link_rate = '0;
  logic [7:0]     in_given_k = '0;
  logic [Q_W-1:0] in_loss_fraction = '0;
  logic           in_loss_known = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [7:0]     out_k_out;
  logic [7:0]     out_n_out;
  logic [1:0]     out_status;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [7:0]     cfg_data = '0;
  int             errors;
  int             pending;
  bit             calm = 1'b0;   // set for the final stretch: no idling on either side
  int             stall_left = 0;

  always #5 clk = ~clk;

  fec_block_sizing i_dut (.*);

  fec_block_sizing_check i_check (.*);

  // Receiver side: random stall bursts, released for the calm stretch.
  always @(posedge clk) begin
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one request and hold it until the block takes it; maybe idle afterwards.
  task automatic send_request(logic [1:0] cmd, logic [31:0] coh, logic [15:0] bytes,
                              logic [31:0] extra, logic [15:0] rate, logic [7:0] gk,
                              logic [Q_W-1:0] loss, logic known);
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_coherence_us  <= coh;
    in_packet_bytes  <= bytes;
    in_overhead_us   <= extra;
    in_link_rate     <= rate;
    in_given_k       <= gk;
    in_loss_fraction <= loss;
    in_loss_known    <= known;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Random request: mostly a coherence time sized to fit a sensible packet count,
  // some raw noise across every bit.
  task automatic send_random();
    logic [1:0]     cmd;
    logic [15:0]    bytes, rate;
    logic [31:0]    extra, coh;
    logic [Q_W-1:0] loss;
    longint         dur;
    cmd = ($urandom_range(0, 9) == 0) ? CMD_SPARE_SEL : 2'($urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      loss = Q_W'($urandom_range(0, 131071));
      send_request(cmd, $urandom, 16'($urandom), $urandom, 16'($urandom), 8'($urandom),
                   loss, 1'($urandom_range(0, 1)));
    end else begin
      bytes = 16'($urandom_range(0, 3000));
      rate  = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 2000));
      extra = $urandom_range(0, 400);
      dur   = (rate == 0) ? 0 : (longint'(bytes) * 80) / rate + extra;
      coh   = 32'(dur * $urandom_range(0, 300) + $urandom_range(0, 50));
      loss  = ($urandom_range(0, 9) == 0) ? Q_W'($urandom_range(0, 131071))
                                          : Q_W'($urandom_range(0, 40000));
      send_request(cmd, coh, bytes, extra, rate, 8'($urandom_range(0, 255)), loss,
                   $urandom_range(0, 3) != 0);
    end
  endtask

  // Settings change only with the pipeline empty.
  task automatic write_settings(logic fec, logic [7:0] maxk, logic [7:0] gf);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_FEC;  cfg_data <= {7'd0, fec}; @(posedge clk);
    cfg_index <= CFG_MAXK; cfg_data <= maxk; @(posedge clk);
    cfg_index <= CFG_GF;   cfg_data <= gf;   @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] mk [10] = '{8'd32, 8'd255, 8'd1, 8'd1, 8'd255, 8'd16, 8'd100, 8'd8,
                            8'd64, 8'd200};
    logic [7:0] gl [10] = '{8'd250, 8'd255, 8'd2, 8'd255, 8'd2, 8'd40, 8'd120, 8'd3,
                            8'd250, 8'd60};
    logic       fe [10] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero rate, zero duration, odd selector, huge and unknown loss, k limits.
    send_request(CMD_DATA,    32'd5000, 16'd1500, 32'd0, 16'd0, 8'd4, '0, 1'b1);
    send_request(CMD_RETX,    32'd5000, 16'd1500, 32'd0, 16'd0, 8'd4, '0, 1'b1);
    send_request(CMD_TIMEOUT, 32'd5000, 16'd1500, 32'd0, 16'd0, 8'd4, '0, 1'b1);
    send_request(CMD_DATA,    32'd5000, 16'd0,    32'd0, 16'd540, 8'd4, '0, 1'b1);
    send_request(CMD_SPARE_SEL, 32'd90000, 16'd1500, 32'd20, 16'd540, 8'd6, 17'd6000, 1'b1);
    send_request(CMD_DATA,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd0, Q_ONE, 1'b1);
    send_request(CMD_DATA,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd0, '1, 1'b1);
    send_request(CMD_RETX,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd5, '1, 1'b1);
    send_request(CMD_TIMEOUT, 32'd0, 16'd0, 32'd0, 16'd0, 8'd5, 17'd62000, 1'b1);
    send_request(CMD_DATA,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd0, '0, 1'b0);
    send_request(CMD_TIMEOUT, 32'd0, 16'd0, 32'd0, 16'd0, 8'd5, '0, 1'b0);
    send_request(CMD_RETX,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd5, '0, 1'b0);
    send_request(CMD_TIMEOUT, 32'd0, 16'd0, 32'd0, 16'd0, 8'd0, '0, 1'b1);
    send_request(CMD_TIMEOUT, 32'd0, 16'd0, 32'd0, 16'd0, 8'd255, '0, 1'b1);
    send_request(CMD_TIMEOUT, 32'd0, 16'd0, 32'd0, 16'd0, 8'd31, '0, 1'b1);
    send_request(CMD_RETX,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd0, '0, 1'b1);
    send_request(CMD_RETX,    32'd90000, 16'd1500, 32'd20, 16'd540, 8'd255, '0, 1'b1);
    send_request(CMD_DATA,    '1, 16'd1, 32'd0, 16'hFFFF, 8'd0, '0, 1'b1);
    send_request(CMD_DATA,    '1, '1, '1, '1, '1, '1, 1'b1);
    send_request(CMD_RETX,    '1, 16'd1, 32'd0, 16'hFFFF, 8'd20, 17'd3000, 1'b1);

    for (int p = 0; p < 10; p++) begin
      if (p != 0) write_settings(fe[p], mk[p], gl[p]);
      if (p == 9) calm = 1'b1;
      repeat (163) send_random();
      // two timeout requests with a random nonzero k, checked against this setting's k limit
      repeat (2) send_request(CMD_TIMEOUT, '0, '0, '0, '0, 8'($urandom_range(1, 255)),
                              Q_W'($urandom_range(0, 60000)), 1'b1);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("fec_block_sizing: match");
    else
      $display("fec_block_sizing: mismatch");
    $finish;
  end

  // Run limit: far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("fec_block_sizing: mismatch");
    $finish;
  end
endmodule
